### design/bole_pkg.sv
// ============================================================================
// bole_pkg - shared types and constants of the bounded ordered list engine
// Store geometry, command codes and the internal operation classes.
// ============================================================================
package bole_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int WORD_W = 32;
	localparam int CMD_W  = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT     = 4'd0,
		CMD_INS_FRONT  = 4'd1,
		CMD_INS_BACK   = 4'd2,
		CMD_REMOVE     = 4'd3,
		CMD_REM_FRONT  = 4'd4,
		CMD_REM_BACK   = 4'd5,
		CMD_SELECT     = 4'd6,
		CMD_SEARCH     = 4'd7,
		CMD_REPLACE    = 4'd8
	} cmd_t;

	// Operation class after decode
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_REM,
		OP_SEL,
		OP_SRCH,
		OP_REPL
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_RESP = 3'b100
	} state_t;

endpackage

### design/bounded_ordered_list_engine.sv
// ============================================================================
// bounded_ordered_list_engine - ordered list of signed words in one RAM
// Insert, remove, select, search and replace on a list of up to 64 entries.
// ============================================================================
// One request beat yields exactly one result beat. The list lives in a
// 64 x 32 single-port-write, single-port-read RAM with a registered read, so
// every request is carried out by a sequencer that walks the RAM one entry a
// cycle: insert moves the entries from the tail down to the insert point up
// by one place, remove moves the entries after the removed one down by one
// place, search reads from the head until the first match. Insert at
// index i reads count-i entries, remove at index i reads count-1-i,
// select reads one, search reads through one entry past the first match
// (all count entries when nothing matches), and replace or a rejected
// request reads none. The worst case is a search of a full list with no
// match, limited by the single RAM read port. A held out_stall delays it
// further. A new request beat is taken while an earlier result still sits
// in the output register; the result is then held there until the
// downstream side drops out_stall. The user must write the capacity
// register through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block itself does not enforce it. Values above 64 act as 64 and zero
// blocks every insert. Lowering the capacity below the current count keeps
// the entries and reports full.
// ============================================================================
module bounded_ordered_list_engine
	import bole_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [CNT_W-1:0]         cfg_wr_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [CNT_W-1:0]         position_in,
	input  logic signed [WORD_W-1:0] value_in,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [WORD_W-1:0] data_out,
	output logic [CNT_W-1:0]         found_at,
	output logic [CNT_W-1:0]         count,
	output logic                     is_empty,
	output logic                     is_full
);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]    left_q;      // RAM reads still to issue
	logic [ADDR_W-1:0]   ptr_q;       // next RAM read address
	logic                hit_q;       // search has matched
	logic                rd_v_s1;     // RAM read data valid this cycle
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic [WORD_W-1:0]   rd_data_s1;
	logic                out_valid_q;

	// request held during the walk
	op_t                 op_q;
	logic                ok_q;
	logic [CNT_W-1:0]    idx_q;
	logic [WORD_W-1:0]   val_q;
	logic [CNT_W-1:0]    found_q;
	logic [WORD_W-1:0]   data_q;

	// output register
	logic                ok_q_o;
	logic [WORD_W-1:0]   data_q_o;
	logic [CNT_W-1:0]    found_q_o;
	logic [CNT_W-1:0]    count_q_o;
	logic                empty_q_o;
	logic                full_q_o;

	logic [WORD_W-1:0]   entry_mem_q [DEPTH];

	// ------------------------------------------------------------------
	// Handshake and capacity
	// ------------------------------------------------------------------
	logic             accept;
	logic             slot_free;
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] cnt_m1;
	logic             cnt_nz;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign cap_eff   = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_nz    = (count_q != '0);

	// ------------------------------------------------------------------
	// Request decode: classify, check, and set up the walk
	// ------------------------------------------------------------------
	op_t               d_op;
	logic              d_ok;
	logic [CNT_W-1:0]  d_idx;
	logic [CNT_W-1:0]  d_left;
	logic [ADDR_W-1:0] d_ptr;
	logic [CNT_W-1:0]  d_found;
	logic [CNT_W-1:0]  ins_idx;
	logic [CNT_W-1:0]  rem_idx;
	logic [CNT_W-1:0]  rem_idx_p1;

	always_comb begin
		ins_idx    = position_in;
		rem_idx    = position_in;
		rem_idx_p1 = '0;
		d_op       = OP_NONE;
		d_ok       = 1'b0;
		d_idx      = position_in;
		d_left     = '0;
		d_ptr      = '0;
		d_found    = '0;
		unique case (cmd_t'(cmd))
			CMD_INSERT, CMD_INS_FRONT, CMD_INS_BACK: begin
				if (cmd_t'(cmd) == CMD_INS_FRONT) begin
					ins_idx = '0;
				end else if (cmd_t'(cmd) == CMD_INS_BACK) begin
					ins_idx = count_q;
				end
				d_op  = OP_INS;
				d_idx = ins_idx;
				d_ok  = (ins_idx <= count_q) && (count_q < cap_eff);
				// move entries idx..count-1 up, starting at the tail
				d_left = d_ok ? (count_q - ins_idx) : '0;
				d_ptr  = cnt_m1[ADDR_W-1:0];
			end
			CMD_REMOVE, CMD_REM_FRONT, CMD_REM_BACK: begin
				if (cmd_t'(cmd) == CMD_REM_FRONT) begin
					rem_idx = '0;
				end else if (cmd_t'(cmd) == CMD_REM_BACK) begin
					rem_idx = cnt_m1;
				end
				rem_idx_p1 = rem_idx + CNT_W'(1);
				d_op   = OP_REM;
				d_idx  = rem_idx;
				d_ok   = cnt_nz && (rem_idx < count_q);
				// move entries idx+1..count-1 down, starting at idx+1
				d_left = d_ok ? (cnt_m1 - rem_idx) : '0;
				d_ptr  = rem_idx_p1[ADDR_W-1:0];
			end
			CMD_SELECT: begin
				d_op   = OP_SEL;
				d_ok   = cnt_nz;
				d_left = cnt_nz ? CNT_W'(1) : '0;
				// out-of-range index reads the last entry
				d_ptr  = (position_in < count_q) ? position_in[ADDR_W-1:0]
				                                 : cnt_m1[ADDR_W-1:0];
			end
			CMD_SEARCH: begin
				d_op    = OP_SRCH;
				d_ok    = 1'b1;
				d_left  = count_q;
				d_found = count_q;
			end
			CMD_REPLACE: begin
				d_op = OP_REPL;
				d_ok = cnt_nz && (position_in < count_q);
			end
			default: begin
				d_op = OP_NONE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Walk control
	// ------------------------------------------------------------------
	logic              issue;
	logic              walk_done;
	logic              srch_hit;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign issue     = (state_q == ST_WALK) && (left_q != '0);
	assign walk_done = (state_q == ST_WALK) && (left_q == '0) && !rd_v_s1;
	assign srch_hit  = (state_q == ST_WALK) && rd_v_s1 && (op_q == OP_SRCH) &&
	                   !hit_q && (rd_data_s1 == val_q);

	// Write port: shifted entry while walking, new value when the walk ends.
	// Reads always run ahead of writes in the walk direction, so no entry
	// is written before it has been read.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1;
		wr_data = rd_data_s1;
		if ((state_q == ST_WALK) && rd_v_s1 && (op_q == OP_INS)) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 + ADDR_W'(1);
		end else if ((state_q == ST_WALK) && rd_v_s1 && (op_q == OP_REM)) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - ADDR_W'(1);
		end else if (walk_done && ok_q && ((op_q == OP_INS) || (op_q == OP_REPL))) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[ADDR_W-1:0];
			wr_data = val_q;
		end
	end

	// ------------------------------------------------------------------
	// Entry RAM: one write, one registered read per cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= entry_mem_q[ptr_q];
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CNT_W'(DEPTH);
			left_q      <= '0;
			ptr_q       <= '0;
			hit_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			rd_v_s1 <= issue;
			// load a new result, else drop the one taken downstream
			if ((state_q == ST_RESP) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						left_q  <= d_left;
						ptr_q   <= d_ptr;
						hit_q   <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue) begin
						// stop at the first match; drop the read in flight
						left_q <= srch_hit ? '0 : (left_q - CNT_W'(1));
						// insert walks toward the head, the rest toward the tail
						ptr_q  <= (op_q == OP_INS) ? (ptr_q - ADDR_W'(1))
						                           : (ptr_q + ADDR_W'(1));
					end
					if (srch_hit) begin
						hit_q <= 1'b1;
					end
					if (walk_done) begin
						if (ok_q && (op_q == OP_INS)) begin
							count_q <= count_q + CNT_W'(1);
						end else if (ok_q && (op_q == OP_REM)) begin
							count_q <= cnt_m1;
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ptr_q;
		if (accept) begin
			op_q    <= d_op;
			ok_q    <= d_ok;
			idx_q   <= d_idx;
			val_q   <= value_in;
			found_q <= d_found;
			data_q  <= '0;
		end
		if (srch_hit) begin
			found_q <= CNT_W'(rd_addr_s1);
		end
		if ((state_q == ST_WALK) && rd_v_s1 && (op_q == OP_SEL)) begin
			data_q <= rd_data_s1;
		end
		if ((state_q == ST_RESP) && slot_free) begin
			ok_q_o    <= ok_q;
			data_q_o  <= data_q;
			found_q_o <= found_q;
			count_q_o <= count_q;
			empty_q_o <= !cnt_nz;
			full_q_o  <= (count_q >= cap_eff);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q_o;
	assign data_out  = data_q_o;
	assign found_at  = found_q_o;
	assign count     = count_q_o;
	assign is_empty  = empty_q_o;
	assign is_full   = full_q_o;

endmodule
